// ===== rtl/gdh_pkg.sv =====
// shared types and constants for the grid distance heuristic pipeline
package gdh_pkg;

    localparam int COORD_W      = 15;
    localparam int FLOOR_W      = 4;
    localparam int GRID_W       = 8;
    localparam int EST_W        = 32;
    localparam int SQ_W         = 2 * COORD_W;
    localparam int SUM_W        = SQ_W + 1;
    localparam int FTERM_W      = FLOOR_W + GRID_W;
    localparam int ROOT_W       = 32;
    localparam int REM_W        = ROOT_W + 2;
    localparam int SQRT_WIDE_W  = REM_W + 2;
    localparam int RAD_W        = 32;
    localparam int SQRT_STEPS   = ROOT_W;
    localparam int FRAC_W       = 16;

    localparam logic [GRID_W-1:0] CELL_PITCH_RESET = 8'd16;
    localparam logic [EST_W-1:0]  EST_MAX          = '1;

    // working state carried through the square root pipeline
    typedef struct packed {
        logic [RAD_W-1:0]   rad;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic [FTERM_W-1:0] floor_term;
    } gdh_sqrt_t;

endpackage

// ===== rtl/grid_distance_heuristic_unit.sv =====
// grid distance heuristic: euclidean distance in 16.16 plus floor cost
// pipeline: 36 register stages (3 front stages, 32 square root stages at one root
//   bit each, 1 output stage); every stage holds its own valid bit
// throughput: one transaction per cycle while m_ready does not stall the output
// reset: aresetn synchronous active low, empties the pipeline, cell pitch = 16
module grid_distance_heuristic_unit import gdh_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [GRID_W-1:0]  cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COORD_W-1:0] s_start_x,
    input  logic [COORD_W-1:0] s_start_y,
    input  logic [FLOOR_W-1:0] s_start_floor,
    input  logic [COORD_W-1:0] s_end_x,
    input  logic [COORD_W-1:0] s_end_y,
    input  logic [FLOOR_W-1:0] s_end_floor,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [EST_W-1:0]   m_estimate
);

    logic [GRID_W-1:0] cell_pitch_reg;
    logic              pipe_valid [SQRT_STEPS+1];
    logic              pipe_ready [SQRT_STEPS+1];
    gdh_sqrt_t         pipe_data  [SQRT_STEPS+1];

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_pitch_reg <= CELL_PITCH_RESET;
        end else if (cfg_wr_en) begin
            cell_pitch_reg <= cfg_wr_data;
        end
    end

    gdh_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cell_pitch  (cell_pitch_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .start_x     (s_start_x),
        .start_y     (s_start_y),
        .start_floor (s_start_floor),
        .end_x       (s_end_x),
        .end_y       (s_end_y),
        .end_floor   (s_end_floor),
        .out_valid   (pipe_valid[0]),
        .out_ready   (pipe_ready[0]),
        .out_data    (pipe_data[0])
    );

    // square root pipeline, one root bit per stage
    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        gdh_sqrt_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (pipe_valid[i]),
            .in_ready  (pipe_ready[i]),
            .in_data   (pipe_data[i]),
            .out_valid (pipe_valid[i+1]),
            .out_ready (pipe_ready[i+1]),
            .out_data  (pipe_data[i+1])
        );
    end

    gdh_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pipe_valid[SQRT_STEPS]),
        .in_ready  (pipe_ready[SQRT_STEPS]),
        .in_data   (pipe_data[SQRT_STEPS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .estimate  (m_estimate)
    );

endmodule

// ===== rtl/gdh_front.sv =====
// front end: absolute differences, squares, floor cost and sum of squares
module gdh_front import gdh_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [GRID_W-1:0]  cell_pitch,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [FLOOR_W-1:0] start_floor,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  logic [FLOOR_W-1:0] end_floor,
    output logic               out_valid,
    input  logic               out_ready,
    output gdh_sqrt_t          out_data
);

    logic               a_valid_reg, b_valid_reg, c_valid_reg;
    logic               a_ready, b_ready, c_ready;
    logic [COORD_W-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [FLOOR_W-1:0] df_reg, df_next;
    logic [SQ_W-1:0]    dx2_reg, dy2_reg;
    logic [FTERM_W-1:0] fterm_b_reg, fterm_next;
    gdh_sqrt_t          c_data_reg, c_data_next;

    // per-stage ready: a stage can load when empty or when it drains
    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage a: absolute differences
    assign dx_next = (start_x >= end_x) ? (start_x - end_x) : (end_x - start_x);
    assign dy_next = (start_y >= end_y) ? (start_y - end_y) : (end_y - start_y);
    assign df_next = (start_floor >= end_floor) ? (start_floor - end_floor)
                                                : (end_floor - start_floor);

    // stage b: floor cost product
    assign fterm_next = FTERM_W'(df_reg) * FTERM_W'(cell_pitch);

    // stage c: sum of squares becomes the upper radicand word
    always_comb begin
        c_data_next            = '0;
        c_data_next.rad        = RAD_W'(SUM_W'(dx2_reg) + SUM_W'(dy2_reg));
        c_data_next.floor_term = fterm_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) a_valid_reg <= in_valid;
            if (b_ready) b_valid_reg <= a_valid_reg;
            if (c_ready) c_valid_reg <= b_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (a_ready) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            df_reg <= df_next;
        end
        if (b_ready) begin
            dx2_reg     <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
            dy2_reg     <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
            fterm_b_reg <= fterm_next;
        end
        if (c_ready) begin
            c_data_reg <= c_data_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

endmodule

// ===== rtl/gdh_sqrt_step.sv =====
// one digit of the bit-by-bit square root, registered
module gdh_sqrt_step import gdh_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  gdh_sqrt_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output gdh_sqrt_t out_data
);

    logic                   valid_reg;
    gdh_sqrt_t              data_reg, data_next;
    logic [SQRT_WIDE_W-1:0] rem_shift, trial, diff;

    assign in_ready = !valid_reg || out_ready;

    // bring down the next two radicand bits and try the next root bit
    assign rem_shift = {in_data.rem, in_data.rad[RAD_W-1 -: 2]};
    assign trial     = SQRT_WIDE_W'({in_data.root, 2'b01});
    assign diff      = rem_shift - trial;

    always_comb begin
        data_next            = in_data;
        data_next.rad        = {in_data.rad[RAD_W-3:0], 2'b00};
        if (rem_shift >= trial) begin
            data_next.rem  = diff[REM_W-1:0];
            data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
        end else begin
            data_next.rem  = rem_shift[REM_W-1:0];
            data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/gdh_back.sv =====
// back end: add the floor cost to the distance and hold the result
module gdh_back import gdh_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  gdh_sqrt_t        in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [EST_W-1:0] estimate
);

    logic             valid_reg;
    logic [EST_W-1:0] est_reg, est_next;
    logic [EST_W:0]   total;

    assign in_ready = !valid_reg || out_ready;

    // floor cost scaled to 16.16, saturated sum
    assign total    = (EST_W+1)'(in_data.root)
                    + ((EST_W+1)'(in_data.floor_term) << FRAC_W);
    assign est_next = total[EST_W] ? EST_MAX : total[EST_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            est_reg <= est_next;
        end
    end

    assign out_valid = valid_reg;
    assign estimate  = est_reg;

endmodule

// ===== tb/grid_distance_heuristic_unit_test.sv =====
// testbench for grid_distance_heuristic_unit: directed table, random routes, self-checking
module grid_distance_heuristic_unit_test;
    import gdh_pkg::*;

    localparam int  HALF_PERIOD   = 5;
    localparam int  RESET_CYCLES  = 10;
    localparam int  PIPE_LATENCY  = 36;
    localparam int  SETTLE_CYCLES = PIPE_LATENCY + 8;
    localparam int  PHASE_ITEMS   = 320;
    localparam int  LONG_HOLD     = 400;
    localparam int  CYCLE_LIMIT   = 200000;
    localparam logic [COORD_W-1:0] COORD_MAX = '1;
    localparam logic [FLOOR_W-1:0] FLOOR_MAX = '1;

    // one route query, field order as on the input channel
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [FLOOR_W-1:0] start_floor;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [FLOOR_W-1:0] end_floor;
    } route_t;

    // directed row: route plus an optional hand-computed estimate
    typedef struct packed {
        route_t           route;
        logic             typed;
        logic [EST_W-1:0] estimate;
    } directed_row_t;

    localparam int N_DIRECTED = 18;

    // all rows run at the reset grid size of 16
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{15'd0, 15'd0, 4'd0, 15'd0, 15'd0, 4'd0}, 1'b1, 32'h0000_0000},
        '{'{COORD_MAX, COORD_MAX, FLOOR_MAX, COORD_MAX, COORD_MAX, FLOOR_MAX},
          1'b1, 32'h0000_0000},
        '{'{15'd0, 15'd0, 4'd0, COORD_MAX, 15'd0, 4'd0}, 1'b1, 32'h7FFF_0000},
        '{'{15'd0, 15'd0, 4'd0, 15'd0, COORD_MAX, 4'd0}, 1'b1, 32'h7FFF_0000},
        '{'{COORD_MAX, 15'd0, 4'd0, 15'd0, 15'd0, 4'd0}, 1'b1, 32'h7FFF_0000},
        '{'{15'd5, 15'd5, 4'd0, 15'd5, 15'd5, FLOOR_MAX}, 1'b1, 32'h00F0_0000},
        '{'{15'd5, 15'd5, FLOOR_MAX, 15'd5, 15'd5, 4'd0}, 1'b1, 32'h00F0_0000},
        '{'{15'd0, 15'd0, 4'd0, 15'd3, 15'd4, 4'd0}, 1'b1, 32'h0005_0000},
        '{'{15'd0, 15'd0, 4'd0, 15'd1, 15'd0, 4'd0}, 1'b1, 32'h0001_0000},
        '{'{15'd100, 15'd200, 4'd3, 15'd103, 15'd204, 4'd3}, 1'b1, 32'h0005_0000},
        '{'{15'd0, 15'd0, 4'd0, COORD_MAX, 15'd0, FLOOR_MAX}, 1'b1, 32'h80EF_0000},
        '{'{15'd0, 15'd0, 4'd0, COORD_MAX, COORD_MAX, 4'd0}, 1'b0, 32'h0},
        '{'{15'd0, 15'd0, 4'd0, COORD_MAX, COORD_MAX, FLOOR_MAX}, 1'b0, 32'h0},
        '{'{COORD_MAX, COORD_MAX, FLOOR_MAX, 15'd0, 15'd0, 4'd0}, 1'b0, 32'h0},
        '{'{15'd0, 15'd0, 4'd0, 15'd1, 15'd1, 4'd0}, 1'b0, 32'h0},
        '{'{15'h5555, 15'h2AAA, 4'd5, 15'h2AAA, 15'h5555, 4'd10}, 1'b0, 32'h0},
        '{'{COORD_MAX, 15'd0, 4'd0, 15'd0, COORD_MAX, 4'd1}, 1'b0, 32'h0},
        '{'{15'd1, 15'd2, 4'd7, 15'd2, 15'd1, 4'd8}, 1'b0, 32'h0}
    };

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [GRID_W-1:0]  cfg_wr_data   = '0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [COORD_W-1:0] s_start_x     = '0;
    logic [COORD_W-1:0] s_start_y     = '0;
    logic [FLOOR_W-1:0] s_start_floor = '0;
    logic [COORD_W-1:0] s_end_x       = '0;
    logic [COORD_W-1:0] s_end_y       = '0;
    logic [FLOOR_W-1:0] s_end_floor   = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [EST_W-1:0]   m_estimate;

    logic [GRID_W-1:0]  cell_pitch_now = CELL_PITCH_RESET;
    logic [EST_W-1:0]   estimate_q [$];
    int                 error_cnt     = 0;
    int                 cycle_cnt     = 0;
    int                 snd_idle_pct  = 0;
    int                 rcv_stall_pct = 0;
    logic               pressure_on   = 1'b0;
    logic               hold_served   = 1'b0;

    grid_distance_heuristic_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_start_floor (s_start_floor),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .s_end_floor   (s_end_floor),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_estimate    (m_estimate)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // floor of the square root, one root bit per step from the top
    function automatic logic [31:0] floor_sqrt64(input logic [63:0] value);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (32'd1 << i);
            if ({32'd0, trial} * {32'd0, trial} <= value)
                root = trial;
        end
        return root;
    endfunction

    // planar distance in 16.16 plus floor cost, saturated to 32 bits
    function automatic logic [EST_W-1:0] predict_estimate(input route_t r,
                                                        input logic [GRID_W-1:0] grid);
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] dfloor;
        logic [63:0] plane_dist;
        logic [63:0] floor_cost;
        logic [63:0] total;
        dx = (r.start_x >= r.end_x) ? 64'(r.start_x - r.end_x) : 64'(r.end_x - r.start_x);
        dy = (r.start_y >= r.end_y) ? 64'(r.start_y - r.end_y) : 64'(r.end_y - r.start_y);
        dfloor = (r.start_floor >= r.end_floor) ? 64'(r.start_floor - r.end_floor)
                                                : 64'(r.end_floor - r.start_floor);
        plane_dist = 64'(floor_sqrt64((dx * dx + dy * dy) << 32));
        floor_cost = (dfloor * 64'(grid)) << FRAC_W;
        total = plane_dist + floor_cost;
        if (total > 64'h0000_0000_FFFF_FFFF)
            total = 64'h0000_0000_FFFF_FFFF;
        return total[EST_W-1:0];
    endfunction

    // random route, weighted toward identical points, same floors, short hops and corners
    function automatic route_t random_route();
        route_t r;
        int     kind;
        kind = $urandom_range(0, 9);
        r.start_x     = COORD_W'($urandom);
        r.start_y     = COORD_W'($urandom);
        r.start_floor = FLOOR_W'($urandom);
        r.end_x       = COORD_W'($urandom);
        r.end_y       = COORD_W'($urandom);
        r.end_floor   = FLOOR_W'($urandom);
        case (kind)
            0: begin
                r.end_x     = r.start_x;
                r.end_y     = r.start_y;
                r.end_floor = r.start_floor;
            end
            1: begin
                r.end_floor = r.start_floor;
            end
            2, 3: begin
                r.end_x = r.start_x + COORD_W'($urandom_range(0, 31)) - COORD_W'(16);
                r.end_y = r.start_y + COORD_W'($urandom_range(0, 31)) - COORD_W'(16);
            end
            4: begin
                r.start_x     = $urandom_range(0, 1) ? COORD_MAX : '0;
                r.start_y     = $urandom_range(0, 1) ? COORD_MAX : '0;
                r.start_floor = $urandom_range(0, 1) ? FLOOR_MAX : '0;
                r.end_x       = $urandom_range(0, 1) ? COORD_MAX : '0;
                r.end_y       = $urandom_range(0, 1) ? COORD_MAX : '0;
                r.end_floor   = $urandom_range(0, 1) ? FLOOR_MAX : '0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // offer one route, with random idle cycles first; returns at the accepting edge
    task automatic offer_route(input route_t r, input logic typed,
                               input logic [EST_W-1:0] typed_est);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_start_x     <= r.start_x;
        s_start_y     <= r.start_y;
        s_start_floor <= r.start_floor;
        s_end_x       <= r.end_x;
        s_end_y       <= r.end_y;
        s_end_floor   <= r.end_floor;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        estimate_q.insert(estimate_q.size(),
                          typed ? typed_est : predict_estimate(r, cell_pitch_now));
    endtask

    // stop offering, wait for every result, then let the pipeline settle
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (estimate_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write while the pipeline is empty
    task automatic write_cell_pitch(input logic [GRID_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        cell_pitch_now = value;
    endtask

    task automatic run_random_phase(input logic [GRID_W-1:0] grid, input int snd_pct,
                                    input int rcv_pct, input logic pressure);
        write_cell_pitch(grid);
        snd_idle_pct = snd_pct;
        rcv_stall_pct <= rcv_pct;
        pressure_on   <= pressure;
        for (int i = 0; i < PHASE_ITEMS; i++)
            offer_route(random_route(), 1'b0, '0);
        pressure_on <= 1'b0;
        drain_pipeline();
    endtask

    // result side: random stalls, plus one long hold-off while the sender keeps going
    initial begin : result_receiver
        forever begin
            @(posedge aclk);
            if (pressure_on && !hold_served) begin
                m_ready <= 1'b0;
                hold_served = 1'b1;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
            end
        end
    end

    // compare each result transaction with the oldest expected estimate
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (estimate_q.size() == 0) begin
                $error("estimate: unexpected result, actual %h", m_estimate);
                error_cnt++;
            end else if (m_estimate !== estimate_q[0]) begin
                $error("estimate mismatch: expected %h, actual %h", estimate_q[0],
                       m_estimate);
                error_cnt++;
                void'(estimate_q.pop_front());
            end else begin
                void'(estimate_q.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("grid_distance_heuristic_unit_test: errors");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table at the reset grid size, no idling
        for (int i = 0; i < N_DIRECTED; i++)
            offer_route(DIRECTED_ROWS[i].route, DIRECTED_ROWS[i].typed,
                        DIRECTED_ROWS[i].estimate);
        drain_pipeline();

        // random phases over grid sizes and idle patterns
        run_random_phase(8'd1, 0, 0, 1'b0);
        run_random_phase(8'd255, 76, 0, 1'b0);
        run_random_phase(8'd0, 0, 76, 1'b0);
        run_random_phase(GRID_W'($urandom_range(2, 254)), 18, 18, 1'b0);
        run_random_phase(8'd255, 0, 0, 1'b1);

        if (error_cnt == 0 && estimate_q.size() == 0) begin
            $display("grid_distance_heuristic_unit_test: clean");
        end else begin
            $display("grid_distance_heuristic_unit_test: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gdh_pkg.sv
rtl/gdh_front.sv
rtl/gdh_sqrt_step.sv
rtl/gdh_back.sv
rtl/grid_distance_heuristic_unit.sv
tb/grid_distance_heuristic_unit_test.sv
